@@ design/tdcfh_pkg.sv @@
package tdcfh_pkg;

   localparam int CHANNELS    = 768;
   localparam int FINE_BINS   = 512;
   localparam int COUNT_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;

   localparam int CHAN_BITS = 10;
   localparam int FINE_BITS = 9;
   localparam int TYPE_BITS = 4;
   localparam int FIFO_BITS = 5;
   localparam int COL_BITS  = 3;
   localparam int PIX_BITS  = 2;
   localparam int TDC_BITS  = 2;

   localparam int DEPTH     = CHANNELS * FINE_BINS;
   localparam int ADDR_BITS = $clog2(DEPTH);

   localparam logic [TYPE_BITS-1:0]   HIT_TYPE_RESET = TYPE_BITS'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = '1;
   localparam logic [ADDR_BITS-1:0]   LAST_ADDR      = ADDR_BITS'(DEPTH - 1);

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] bin_count;
      logic                 count_saturated;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } push_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } queue_status_type;

   function automatic logic [ADDR_BITS-1:0] bin_addr(input logic [CHAN_BITS-1:0] chan,
                                                     input logic [FINE_BITS-1:0] fine);
      bin_addr = ADDR_BITS'(chan) * ADDR_BITS'(FINE_BINS) + ADDR_BITS'(fine);
   endfunction

   function automatic logic [OUT_WIDTH-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
      logic [COUNT_WIDTH+OUT_WIDTH-1:0] w;
      w = {{OUT_WIDTH{1'b0}}, c};
      if (w > (COUNT_WIDTH+OUT_WIDTH)'({OUT_WIDTH{1'b1}})) begin
         return '1;
      end
      return OUT_WIDTH'(w);
   endfunction

endpackage

@@ design/tdcfh_req_if.sv @@
interface tdcfh_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [tdcfh_pkg::TYPE_BITS-1:0] record_type;
   logic [tdcfh_pkg::FIFO_BITS-1:0] fifo;
   logic [tdcfh_pkg::COL_BITS-1:0]  column;
   logic [tdcfh_pkg::PIX_BITS-1:0]  pixel;
   logic [tdcfh_pkg::TDC_BITS-1:0]  tdc;
   logic [tdcfh_pkg::FINE_BITS-1:0] fine;
   logic [tdcfh_pkg::CHAN_BITS-1:0] read_channel;
   logic [tdcfh_pkg::FINE_BITS-1:0] read_bin;

   modport source (output valid, kind, record_type, fifo, column, pixel, tdc, fine,
                   read_channel, read_bin, input ready);
   modport sink   (input valid, kind, record_type, fifo, column, pixel, tdc, fine,
                   read_channel, read_bin, output ready);
endinterface

@@ design/tdcfh_rsp_if.sv @@
interface tdcfh_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tdcfh_pkg::OUT_WIDTH-1:0] bin_count;
   logic                            count_saturated;

   modport source (output valid, bin_count, count_saturated, input ready);
   modport sink   (input valid, bin_count, count_saturated, output ready);
endinterface

@@ design/tdcfh_ram.sv @@
module tdcfh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/tdcfh_out_queue.sv @@
module tdcfh_out_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  tdcfh_pkg::push_type                 push,
   output tdcfh_pkg::queue_status_type         status,
   tdcfh_rsp_if.source                         rsp_ch
);

   tdcfh_pkg::result_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       pop;

   assign rsp_ch.valid           = (count_ff != 2'd0);
   assign rsp_ch.bin_count       = entry_ff[rd_ptr_ff].bin_count;
   assign rsp_ch.count_saturated = entry_ff[rd_ptr_ff].count_saturated;
   assign pop = rsp_ch.valid && rsp_ch.ready;

   assign status.count = count_ff;
   assign status.pop   = pop;

   always_comb begin
      wr_ptr_in = push.valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.res;
      end
   end

endmodule

@@ design/tdcfh_rmw.sv @@
module tdcfh_rmw (
   input  logic                                 clock,
   input  logic                                 reset,
   tdcfh_req_if.sink                            req_ch,
   input  logic [tdcfh_pkg::TYPE_BITS-1:0]      hit_type,
   input  tdcfh_pkg::queue_status_type          q_status,
   output tdcfh_pkg::push_type                  push
);

   localparam int AW = tdcfh_pkg::ADDR_BITS;
   localparam int CW = tdcfh_pkg::COUNT_WIDTH;

   // clearing sweep after reset
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // stage 1: read data comes back this cycle
   logic          s1_valid_ff;
   logic          s1_read_ff;
   logic          s1_ok_ff;
   logic [AW-1:0] s1_addr_ff;

   // last write, covers the read issued on the same edge
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [CW-1:0] fwd_data_ff;

   logic                             room;
   logic                             accept;
   logic [tdcfh_pkg::CHAN_BITS-1:0]  hit_chan;
   logic                             rec_ok;
   logic                             rd_ok;
   logic                             req_ok;
   logic [AW-1:0]                    raddr;
   logic [CW-1:0]                    rdata;
   logic [CW-1:0]                    cur;
   logic                             cur_max;
   logic                             we;
   logic [AW-1:0]                    waddr;
   logic [CW-1:0]                    wdata;

   always_comb begin
      case (q_status.count)
         2'd0:    room = 1'b1;
         2'd1:    room = !s1_read_ff || !s1_valid_ff || q_status.pop;
         2'd2:    room = q_status.pop && !(s1_valid_ff && s1_read_ff);
         default: room = 1'b0;
      endcase
   end

   assign req_ch.ready = !clr_busy_ff && room;
   assign accept       = req_ch.valid && req_ch.ready;

   // channel = tdc + 4*pixel + 16*column + 128*(fifo/4)
   assign hit_chan = {req_ch.fifo[4:2], req_ch.column, req_ch.pixel, req_ch.tdc};

   always_comb begin
      rec_ok = (req_ch.record_type == hit_type)
               && (32'(hit_chan) < 32'(tdcfh_pkg::CHANNELS))
               && (32'(req_ch.fine) < 32'(tdcfh_pkg::FINE_BINS));
      rd_ok  = (32'(req_ch.read_channel) < 32'(tdcfh_pkg::CHANNELS))
               && (32'(req_ch.read_bin) < 32'(tdcfh_pkg::FINE_BINS));
      if (req_ch.kind == tdcfh_pkg::KIND_READ) begin
         req_ok = rd_ok;
         raddr  = tdcfh_pkg::bin_addr(req_ch.read_channel, req_ch.read_bin);
      end else begin
         req_ok = rec_ok;
         raddr  = tdcfh_pkg::bin_addr(hit_chan, req_ch.fine);
      end
   end

   tdcfh_ram #(
      .WIDTH (CW),
      .DEPTH (tdcfh_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (accept),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign cur     = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rdata;
   assign cur_max = (cur == tdcfh_pkg::COUNT_MAX);

   always_comb begin
      we    = 1'b0;
      waddr = s1_addr_ff;
      wdata = cur + CW'(1);
      if (clr_busy_ff) begin
         we    = 1'b1;
         waddr = clr_addr_ff;
         wdata = '0;
      end else if (s1_valid_ff && !s1_read_ff && s1_ok_ff && !cur_max) begin
         we = 1'b1;
      end
   end

   always_comb begin
      push.valid               = s1_valid_ff && s1_read_ff;
      push.res.bin_count       = s1_ok_ff ? tdcfh_pkg::clip_count(cur) : '0;
      push.res.count_saturated = s1_ok_ff && cur_max;
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == tdcfh_pkg::LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= accept;
         fwd_valid_ff <= we;
      end
      if (accept) begin
         s1_read_ff <= (req_ch.kind == tdcfh_pkg::KIND_READ);
         s1_ok_ff   <= req_ok;
         s1_addr_ff <= raddr;
      end
      fwd_addr_ff <= waddr;
      fwd_data_ff <= wdata;
   end

endmodule

@@ design/tdc_fine_code_histogram.sv @@
// TDC fine-code density histogram.
// req_ch takes one word per cycle while ready: kind 0 records a decoded hit,
// kind 1 reads one bin. A hit whose record_type equals hit_type increments the
// bin (channel, fine), channel = tdc + 4*pixel + 16*column + 128*(fifo/4);
// counts saturate. Other types and out-of-range hits are dropped silently.
// A read returns one word on rsp_ch: the bin count and a saturated flag
// (zero for an out-of-range bin). Record words give no response.
// Throughput: one word per cycle while req_ch.ready is high; the store is read
// on the accept edge and written back on the next, and the last write is
// forwarded to cover a back-to-back hit on the same bin.
// An accepted read word goes through stage 1 into the buffer that drives rsp_ch.
// rsp_ch is buffered two deep; when the receiver stalls, req_ch.ready drops
// once that buffer and the word in flight would overflow it.
// Reset sets the hit_type register to 1 and starts a clearing pass over the
// 393216-entry store, one entry per cycle; req_ch.ready stays low until it ends.
// Write hit_type via csr_we/csr_wdata only while idle; it is not enforced.
module tdc_fine_code_histogram (
   input  logic                            clock,
   input  logic                            reset,
   tdcfh_req_if.sink                       req_ch,
   tdcfh_rsp_if.source                     rsp_ch,
   input  logic                            csr_we,
   input  logic [tdcfh_pkg::TYPE_BITS-1:0] csr_wdata
);

   logic [tdcfh_pkg::TYPE_BITS-1:0] hit_type_ff;
   tdcfh_pkg::push_type             push;
   tdcfh_pkg::queue_status_type     q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_type_ff <= tdcfh_pkg::HIT_TYPE_RESET;
      end else if (csr_we) begin
         hit_type_ff <= csr_wdata;
      end
   end

   tdcfh_rmw u_rmw (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .hit_type (hit_type_ff),
      .q_status (q_status),
      .push     (push)
   );

   tdcfh_out_queue u_out (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .status (q_status),
      .rsp_ch (rsp_ch)
   );

endmodule

@@ sim/tb_tdc_fine_code_histogram.sv @@
module tb_tdc_fine_code_histogram;

   localparam int SETTLE_CYCLES  = 4;
   localparam int IDLE_LIMIT     = 4 * tdcfh_pkg::DEPTH + 50000;
   localparam int PHASE_WORDS    = 155;
   localparam int MAX_REPORTS    = 50;
   localparam int HOT_BINS       = 8;
   localparam int TOUCHED_WINDOW = 64;

   typedef struct {
      logic                            kind;
      logic [tdcfh_pkg::TYPE_BITS-1:0] record_type;
      logic [tdcfh_pkg::FIFO_BITS-1:0] fifo;
      logic [tdcfh_pkg::COL_BITS-1:0]  column;
      logic [tdcfh_pkg::PIX_BITS-1:0]  pixel;
      logic [tdcfh_pkg::TDC_BITS-1:0]  tdc;
      logic [tdcfh_pkg::FINE_BITS-1:0] fine;
      logic [tdcfh_pkg::CHAN_BITS-1:0] read_channel;
      logic [tdcfh_pkg::FINE_BITS-1:0] read_bin;
   } hist_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [tdcfh_pkg::TYPE_BITS-1:0] csr_wdata;

   tdcfh_req_if req_ch ();
   tdcfh_rsp_if rsp_ch ();

   tdc_fine_code_histogram u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block: sparse bin store, hit type, reads awaiting their word
   logic [tdcfh_pkg::COUNT_WIDTH-1:0] bin_counts [int unsigned];
   logic [tdcfh_pkg::TYPE_BITS-1:0]   hit_type_shadow = tdcfh_pkg::HIT_TYPE_RESET;
   tdcfh_pkg::result_type             pending_reads [$];
   int unsigned                       touched_bins [$];
   int unsigned                       hot_bins [HOT_BINS];

   bit req_steady;
   bit rsp_steady;
   int rsp_hold_request;
   int idle_cycles;
   int mismatches;
   int words_sent;
   int hits_counted;
   int records_dropped;
   int reads_checked;
   int reads_off_table;
   int settings_used;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   // Histogram update / lookup for one accepted word.
   function automatic void account_word(input hist_word_type w);
      int unsigned chan;
      int unsigned addr;
      logic [tdcfh_pkg::COUNT_WIDTH-1:0] cnt;
      logic [63:0] wide;
      tdcfh_pkg::result_type want;
      if (w.kind == tdcfh_pkg::KIND_RECORD) begin
         if (w.record_type != hit_type_shadow) begin
            records_dropped++;
            return;
         end
         // chip = fifo/4 lands on bits 9:7, then column, pixel, tdc
         chan = {w.fifo[tdcfh_pkg::FIFO_BITS-1:2], w.column, w.pixel, w.tdc};
         if (chan >= tdcfh_pkg::CHANNELS || w.fine >= tdcfh_pkg::FINE_BINS) begin
            records_dropped++;
            return;
         end
         addr = chan * tdcfh_pkg::FINE_BINS + w.fine;
         cnt = bin_counts.exists(addr) ? bin_counts[addr] : '0;
         if (cnt != tdcfh_pkg::COUNT_MAX) bin_counts[addr] = cnt + 1'b1;
         hits_counted++;
         touched_bins.push_back(addr);
         if (touched_bins.size() > TOUCHED_WINDOW) void'(touched_bins.pop_front());
      end else begin
         want = '0;
         if (w.read_channel < tdcfh_pkg::CHANNELS && w.read_bin < tdcfh_pkg::FINE_BINS) begin
            addr = w.read_channel * tdcfh_pkg::FINE_BINS + w.read_bin;
            cnt = bin_counts.exists(addr) ? bin_counts[addr] : '0;
            wide = 64'(cnt);
            want.bin_count = (wide > 64'({tdcfh_pkg::OUT_WIDTH{1'b1}})) ?
                             '1 : wide[tdcfh_pkg::OUT_WIDTH-1:0];
            want.count_saturated = (cnt == tdcfh_pkg::COUNT_MAX);
         end else begin
            reads_off_table++;
         end
         pending_reads.push_back(want);
      end
   endfunction

   function automatic hist_word_type noise_word();
      hist_word_type w;
      w.kind         = 1'($urandom);
      w.record_type  = tdcfh_pkg::TYPE_BITS'($urandom);
      w.fifo         = tdcfh_pkg::FIFO_BITS'($urandom);
      w.column       = tdcfh_pkg::COL_BITS'($urandom);
      w.pixel        = tdcfh_pkg::PIX_BITS'($urandom);
      w.tdc          = tdcfh_pkg::TDC_BITS'($urandom);
      w.fine         = tdcfh_pkg::FINE_BITS'($urandom);
      w.read_channel = tdcfh_pkg::CHAN_BITS'($urandom);
      w.read_bin     = tdcfh_pkg::FINE_BITS'($urandom);
      return w;
   endfunction

   // chan may run up to 1023 so that fifo 24..31 can be produced
   function automatic hist_word_type hit_word(input int unsigned chan,
                                              input int unsigned fine_code,
                                              input logic [tdcfh_pkg::TYPE_BITS-1:0] rtype);
      hist_word_type w;
      w = noise_word();
      w.kind        = tdcfh_pkg::KIND_RECORD;
      w.record_type = rtype;
      w.fifo        = tdcfh_pkg::FIFO_BITS'((chan >> 7) * 4 + $urandom_range(3));
      w.column      = chan[6:4];
      w.pixel       = chan[3:2];
      w.tdc         = chan[1:0];
      w.fine        = tdcfh_pkg::FINE_BITS'(fine_code);
      return w;
   endfunction

   function automatic hist_word_type read_word(input int unsigned chan, input int unsigned bin);
      hist_word_type w;
      w = noise_word();
      w.kind         = tdcfh_pkg::KIND_READ;
      w.read_channel = tdcfh_pkg::CHAN_BITS'(chan);
      w.read_bin     = tdcfh_pkg::FINE_BITS'(bin);
      return w;
   endfunction

   task automatic send_word(input hist_word_type w);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= w.kind;
      req_ch.record_type  <= w.record_type;
      req_ch.fifo         <= w.fifo;
      req_ch.column       <= w.column;
      req_ch.pixel        <= w.pixel;
      req_ch.tdc          <= w.tdc;
      req_ch.fine         <= w.fine;
      req_ch.read_channel <= w.read_channel;
      req_ch.read_bin     <= w.read_bin;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      account_word(w);
      words_sent++;
   endtask

   // stop offering words, let every read word come back, then let the pipe settle
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_hit_type(input logic [tdcfh_pkg::TYPE_BITS-1:0] value);
      quiesce();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      hit_type_shadow = value;
      settings_used++;
   endtask

   task automatic test_directed_bins();
      req_steady = 1'b1;
      send_word(hit_word(0, 0, tdcfh_pkg::HIT_TYPE_RESET));
      send_word(hit_word(0, 0, tdcfh_pkg::HIT_TYPE_RESET));
      send_word(read_word(0, 0));
      send_word(hit_word(tdcfh_pkg::CHANNELS - 1, tdcfh_pkg::FINE_BINS - 1,
                         tdcfh_pkg::HIT_TYPE_RESET));
      send_word(read_word(tdcfh_pkg::CHANNELS - 1, tdcfh_pkg::FINE_BINS - 1));
      // other record types must not touch the store
      send_word(hit_word(0, 0, 4'd0));
      send_word(hit_word(tdcfh_pkg::CHANNELS - 1, tdcfh_pkg::FINE_BINS - 1, 4'd15));
      // fifo 24..31 yields a channel past the table
      send_word(hit_word(1023, tdcfh_pkg::FINE_BINS - 1, tdcfh_pkg::HIT_TYPE_RESET));
      send_word(hit_word(tdcfh_pkg::CHANNELS, 0, tdcfh_pkg::HIT_TYPE_RESET));
      send_word(read_word(0, 0));
      send_word(read_word(tdcfh_pkg::CHANNELS - 1, tdcfh_pkg::FINE_BINS - 1));
      send_word(read_word(tdcfh_pkg::CHANNELS, 0));
      send_word(read_word(1023, tdcfh_pkg::FINE_BINS - 1));
      send_word(read_word(0, tdcfh_pkg::FINE_BINS - 1));
      // back-to-back hits on one bin exercise the write-back bypass
      send_word(hit_word(300, 257, tdcfh_pkg::HIT_TYPE_RESET));
      send_word(hit_word(300, 257, tdcfh_pkg::HIT_TYPE_RESET));
      send_word(hit_word(300, 257, tdcfh_pkg::HIT_TYPE_RESET));
      send_word(read_word(300, 257));
      send_word(hit_word(300, 256, tdcfh_pkg::HIT_TYPE_RESET));
      send_word(read_word(300, 257));
      send_word(read_word(300, 256));
      req_steady = 1'b0;
      quiesce();
   endtask

   function automatic int unsigned pick_bin();
      int r;
      r = $urandom_range(99);
      if (r < 45) return hot_bins[$urandom_range(HOT_BINS - 1)];
      if (r < 90) return $urandom_range(tdcfh_pkg::DEPTH - 1);
      return $urandom_range(tdcfh_pkg::CHANNELS * tdcfh_pkg::FINE_BINS,
                            1024 * tdcfh_pkg::FINE_BINS - 1);
   endfunction

   task automatic send_random_word();
      hist_word_type w;
      int r;
      int unsigned addr;
      logic [tdcfh_pkg::TYPE_BITS-1:0] rtype;
      r = $urandom_range(99);
      if (r < 5) begin
         w = noise_word();
      end else if (r < 67) begin
         addr = pick_bin();
         rtype = ($urandom_range(99) < 75) ? hit_type_shadow :
                 tdcfh_pkg::TYPE_BITS'($urandom);
         w = hit_word(addr / tdcfh_pkg::FINE_BINS, addr % tdcfh_pkg::FINE_BINS, rtype);
      end else begin
         r = $urandom_range(99);
         if (r < 55 && touched_bins.size() != 0)
            addr = touched_bins[$urandom_range(touched_bins.size() - 1)];
         else if (r < 85)
            addr = $urandom_range(1024 * tdcfh_pkg::FINE_BINS - 1);
         else
            addr = hot_bins[$urandom_range(HOT_BINS - 1)];
         w = read_word(addr / tdcfh_pkg::FINE_BINS, addr % tdcfh_pkg::FINE_BINS);
      end
      send_word(w);
   endtask

   task automatic test_random_phases();
      logic [tdcfh_pkg::TYPE_BITS-1:0] phase_types [8];
      int p;
      int i;
      phase_types = '{4'd0, 4'd15, tdcfh_pkg::HIT_TYPE_RESET, tdcfh_pkg::TYPE_BITS'($urandom),
                      4'd7, tdcfh_pkg::TYPE_BITS'($urandom), 4'd15,
                      tdcfh_pkg::HIT_TYPE_RESET};
      for (p = 0; p < 8; p++) begin
         for (i = 0; i < HOT_BINS; i++) hot_bins[i] = $urandom_range(tdcfh_pkg::DEPTH - 1);
         write_hit_type(phase_types[p]);
         req_steady = (p == 2 || p == 5);
         rsp_steady = (p == 2 || p == 5);
         for (i = 0; i < PHASE_WORDS; i++) send_random_word();
         req_steady = 1'b0;
         rsp_steady = 1'b0;
      end
   endtask

   // receiver holds off long enough for the block to fill and stall its input
   task automatic test_output_backpressure();
      int i;
      int unsigned addr;
      quiesce();
      rsp_hold_request = 400;
      req_steady = 1'b1;
      for (i = 0; i < 40; i++) begin
         addr = hot_bins[$urandom_range(HOT_BINS - 1)];
         if (i % 4 == 3)
            send_word(hit_word(addr / tdcfh_pkg::FINE_BINS, addr % tdcfh_pkg::FINE_BINS,
                               hit_type_shadow));
         else
            send_word(read_word(addr / tdcfh_pkg::FINE_BINS, addr % tdcfh_pkg::FINE_BINS));
      end
      req_steady = 1'b0;
      quiesce();
   endtask

   initial begin : rsp_sink
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request > 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            stall = rsp_steady ? 0 : pick_gap();
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_results
      tdcfh_pkg::result_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("word with no read outstanding", rsp_ch.bin_count, 0);
         end else begin
            want = pending_reads.pop_front();
            if (rsp_ch.bin_count !== want.bin_count)
               report_mismatch("bin_count", rsp_ch.bin_count, want.bin_count);
            if (rsp_ch.count_saturated !== want.count_saturated)
               report_mismatch("count_saturated", rsp_ch.count_saturated,
                               want.count_saturated);
            reads_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = tdcfh_pkg::KIND_RECORD;
      req_ch.record_type = '0;
      req_ch.fifo = '0;
      req_ch.column = '0;
      req_ch.pixel = '0;
      req_ch.tdc = '0;
      req_ch.fine = '0;
      req_ch.read_channel = '0;
      req_ch.read_bin = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_bins();
      test_random_phases();
      test_output_backpressure();
      write_hit_type(tdcfh_pkg::HIT_TYPE_RESET);
      quiesce();

      $display("%0d words sent: %0d hits counted, %0d records dropped, %0d reads checked",
               words_sent, hits_counted, records_dropped, reads_checked);
      $display("%0d reads off the table, %0d hit type settings, %0d mismatches",
               reads_off_table, settings_used, mismatches);
      if (mismatches == 0 && pending_reads.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ tdc_fine_code_histogram.f @@
design/tdcfh_pkg.sv
design/tdcfh_req_if.sv
design/tdcfh_rsp_if.sv
design/tdcfh_ram.sv
design/tdcfh_out_queue.sv
design/tdcfh_rmw.sv
design/tdc_fine_code_histogram.sv
sim/tb_tdc_fine_code_histogram.sv
